/* sv/ard_pkg.sv */
// shared types and constants for the adaptive replacement directory
package ard_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;
  localparam int AGE_BITS        = 48;
  localparam int FRAC_BITS       = 8;
  localparam int CAP_W           = 7;
  localparam int P_OUT_W         = 15;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] GHOST_NONE = 2'd0;
  localparam logic [1:0] GHOST_B1   = 2'd1;
  localparam logic [1:0] GHOST_B2   = 2'd2;

  typedef enum logic [1:0] {
    L_T1 = 2'd0,
    L_T2 = 2'd1,
    L_B1 = 2'd2,
    L_B2 = 2'd3
  } list_t;

  typedef enum logic [1:0] {
    Q_MATCH = 2'd0,
    Q_LRU   = 2'd1,
    Q_FREE  = 2'd2
  } qkind_t;

  typedef enum logic [1:0] {
    U_NONE   = 2'd0,
    U_MOVE   = 2'd1,
    U_DROP   = 2'd2,
    U_INSERT = 2'd3
  } uop_t;

  // control part of the search token walking down the cell row
  typedef struct packed {
    logic   go;
    qkind_t kind;
    list_t  list;
    logic   found;
    list_t  clist;
  } tok_t;

  // control part of the broadcast cell update
  typedef struct packed {
    uop_t  op;
    list_t list;
  } upd_t;

  typedef struct packed {
    logic [31:0] key;
    logic        high_freq;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [1:0]           ghost_kind;
    logic                 evicted_valid;
    logic [31:0]          evicted_key;
    logic [P_OUT_W-1:0]   target_t1;
    logic [31:0]          hit_total;
    logic [31:0]          miss_total;
  } rsp_t;

endpackage

/* sv/ard_cell.sv */
// one directory cell: holds an entry and passes the search token on
module ard_cell
  import ard_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  tok_t                tok_in,
  input  logic [KEY_BITS-1:0] qkey_in,
  input  logic [IDX_W-1:0]    idx_in,
  input  logic [AGE_BITS-1:0] age_in,
  input  logic [KEY_BITS-1:0] ckey_in,
  output tok_t                tok_out,
  output logic [KEY_BITS-1:0] qkey_out,
  output logic [IDX_W-1:0]    idx_out,
  output logic [AGE_BITS-1:0] age_out,
  output logic [KEY_BITS-1:0] ckey_out,
  input  upd_t                upd,
  input  logic [IDX_W-1:0]    upd_idx,
  input  logic [KEY_BITS-1:0] upd_key,
  input  logic [AGE_BITS-1:0] upd_age
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                valid;
  logic [KEY_BITS-1:0] key;
  list_t               list;
  logic [AGE_BITS-1:0] age;
  logic                take;

  always_comb begin
    case (tok_in.kind)
      Q_MATCH: take = !tok_in.found && valid && (key == qkey_in);
      Q_LRU:   take = valid && (list == tok_in.list) &&
                      (!tok_in.found || (age < age_in));
      Q_FREE:  take = !tok_in.found && !valid;
      default: take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.go <= 1'b0;
      valid      <= 1'b0;
    end else begin
      tok_out.go <= tok_in.go;
      if (upd.op != U_NONE && upd_idx == MY_IDX) begin
        case (upd.op)
          U_MOVE: begin
            list <= upd.list;
            age  <= upd_age;
          end
          U_DROP: valid <= 1'b0;
          U_INSERT: begin
            valid <= 1'b1;
            key   <= upd_key;
            list  <= upd.list;
            age   <= upd_age;
          end
          default: ;
        endcase
      end
    end
    tok_out.kind <= tok_in.kind;
    tok_out.list <= tok_in.list;
    qkey_out     <= qkey_in;
    if (take) begin
      tok_out.found <= 1'b1;
      tok_out.clist <= list;
      idx_out       <= MY_IDX;
      age_out       <= age;
      ckey_out      <= key;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.clist <= tok_in.clist;
      idx_out       <= idx_in;
      age_out       <= age_in;
      ckey_out      <= ckey_in;
    end
  end

endmodule

/* sv/ard_div.sv */
// bit-serial restoring divider for the ghost size ratio, (num << 8) / den
module ard_div
  import ard_pkg::*;
#(
  parameter int NW = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NW-1:0]           num,
  input  logic [NW-1:0]           den,
  output logic                    done,
  output logic [NW+FRAC_BITS-1:0] quo
);

  localparam int QW = NW + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [NW:0]   rem;
  logic [QW-1:0] dvd;
  logic [NW-1:0] d;
  logic [NW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem[NW-1:0], dvd[QW-1]};
  assign ge     = rem_sh >= {1'b0, d};
  assign quo    = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(QW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
    if (start) begin
      dvd <= {num, {FRAC_BITS{1'b0}}};
      rem <= '0;
      d   <= den;
    end else if (run) begin
      rem <= ge ? (rem_sh - {1'b0, d}) : rem_sh;
      dvd <= {dvd[QW-2:0], ge};
    end
  end

endmodule

/* sv/adaptive_replacement_directory.sv */
// adaptive replacement directory: ARC lists kept in a row of search cells
// each search walks all 2*MAX_ENTRIES cells of the row;
//   an item needs one to seven searches plus, on a ghost hit where the other ghost list is
//   the larger, a serial divide, and the setup and result states
// throughput: one item at a time; busy stays high until the result strobe has gone
// reset: rst clears all valid bits, list sizes, target, totals; capacity returns to 64
// the result strobe lasts one cycle and is not held off
module adaptive_replacement_directory
  import ard_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             item,
  output logic             result_valid,
  output rsp_t             result,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int CELLS = 2 * MAX_ENTRIES;
  localparam int IDX_W = $clog2(CELLS);
  localparam int SZ_W  = $clog2(CELLS + 1);
  localparam int DQ    = SZ_W + FRAC_BITS;
  localparam int P_W   = $clog2(MAX_ENTRIES * 256 + 1);
  localparam int EW    = DQ + 1;
  localparam int TW    = SZ_W + 2;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_FIND   = 12'b000000000010,
    S_DIV    = 12'b000000000100,
    S_TRIM   = 12'b000000001000,
    S_REPL   = 12'b000000010000,
    S_REPL2  = 12'b000000100000,
    S_MOVEK  = 12'b000001000000,
    S_FREE   = 12'b000010000000,
    S_VICB2  = 12'b000100000000,
    S_VICB1  = 12'b001000000000,
    S_INSERT = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t              state;
  logic                issued;
  logic [CAP_W-1:0]    cap;
  logic [SZ_W-1:0]     sz [4];
  logic [SZ_W-1:0]     sz_next [4];
  logic [P_W-1:0]      p;
  logic [31:0]         hits;
  logic [31:0]         misses;
  logic [AGE_BITS-1:0] age_now;
  logic                hit_r;
  logic [1:0]          ghost_r;
  logic                ev_valid;
  logic [KEY_BITS-1:0] ev_key;
  logic [KEY_BITS-1:0] kreg;
  logic                hf;
  logic [IDX_W-1:0]    midx;
  list_t               mlist;
  logic [IDX_W-1:0]    fidx;
  logic                in_b2;
  list_t               trim_list;
  logic                trim_evict;
  logic                div_need;

  // cell row wiring
  tok_t                tok_c  [CELLS+1];
  logic [KEY_BITS-1:0] qkey_c [CELLS+1];
  logic [IDX_W-1:0]    idx_c  [CELLS+1];
  logic [AGE_BITS-1:0] age_c  [CELLS+1];
  logic [KEY_BITS-1:0] ckey_c [CELLS+1];

  logic                q_go;
  qkind_t              q_kind;
  list_t               q_list;
  upd_t                upd;
  logic [IDX_W-1:0]    upd_idx;
  list_t               old_l;

  logic                done_q;
  logic                fnd;
  logic [IDX_W-1:0]    ridx;
  list_t               rlist;

  logic [TW-1:0]       c;
  logic [TW-1:0]       t1;
  logic [TW-1:0]       t1b1;
  logic [TW-1:0]       tot;
  logic [EW-1:0]       whole;
  logic                ch_t1;
  list_t               rep_list;
  state_t              after_rep;

  logic                div_start;
  logic                div_done;
  logic [SZ_W-1:0]     div_num;
  logic [SZ_W-1:0]     div_den;
  logic [DQ-1:0]       quo;
  logic [EW-1:0]       delta;
  logic [EW-1:0]       p_sum;
  logic [EW-1:0]       cap_fx;
  logic [EW-1:0]       p_ext;

  assign tok_c[0].go    = q_go;
  assign tok_c[0].kind  = q_kind;
  assign tok_c[0].list  = q_list;
  assign tok_c[0].found = 1'b0;
  assign tok_c[0].clist = L_T1;
  assign qkey_c[0]      = kreg;
  assign idx_c[0]       = '0;
  assign age_c[0]       = '0;
  assign ckey_c[0]      = '0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    ard_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_c[g]),
      .qkey_in  (qkey_c[g]),
      .idx_in   (idx_c[g]),
      .age_in   (age_c[g]),
      .ckey_in  (ckey_c[g]),
      .tok_out  (tok_c[g+1]),
      .qkey_out (qkey_c[g+1]),
      .idx_out  (idx_c[g+1]),
      .age_out  (age_c[g+1]),
      .ckey_out (ckey_c[g+1]),
      .upd      (upd),
      .upd_idx  (upd_idx),
      .upd_key  (kreg),
      .upd_age  (age_now + AGE_BITS'(1))
    );
  end

  assign done_q = tok_c[CELLS].go;
  assign fnd    = tok_c[CELLS].found;
  assign ridx   = idx_c[CELLS];
  assign rlist  = tok_c[CELLS].clist;

  // capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    if (cap == '0) begin
      c = TW'(1);
    end else if (32'(cap) > 32'(MAX_ENTRIES)) begin
      c = TW'(MAX_ENTRIES);
    end else begin
      c = TW'(cap);
    end
  end

  assign t1    = TW'(sz[L_T1]);
  assign t1b1  = TW'(sz[L_T1]) + TW'(sz[L_B1]);
  assign tot   = TW'(sz[L_T1]) + TW'(sz[L_T2]) + TW'(sz[L_B1]) + TW'(sz[L_B2]);
  assign whole = EW'(p >> FRAC_BITS);
  assign ch_t1 = (t1 != '0) &&
                 ((EW'(t1) > whole) || (in_b2 && (EW'(t1) == whole)));
  assign rep_list  = ch_t1 ? L_T1 : L_T2;
  assign after_rep = (ghost_r != GHOST_NONE) ? S_MOVEK : S_FREE;

  // ghost ratio divider
  assign div_num = (rlist == L_B1) ? sz[L_B2] : sz[L_B1];
  assign div_den = (rlist == L_B1) ? sz[L_B1] : sz[L_B2];

  always_comb begin
    div_start = 1'b0;
    if (state == S_FIND && done_q && fnd && (rlist == L_B1 || rlist == L_B2)) begin
      div_start = !((div_den >= div_num) || (div_den == '0));
    end
  end

  ard_div #(
    .NW (SZ_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign delta  = div_need ? EW'(quo) : (EW'(1) << FRAC_BITS);
  assign p_ext  = EW'(p);
  assign p_sum  = p_ext + delta;
  assign cap_fx = EW'(c) << FRAC_BITS;

  // search issue and cell update
  always_comb begin
    q_go    = 1'b0;
    q_kind  = Q_MATCH;
    q_list  = L_T1;
    upd.op  = U_NONE;
    upd.list = L_T1;
    upd_idx = ridx;
    old_l   = rlist;
    case (state)
      S_FIND: begin
        q_go = !issued;
        if (done_q && fnd && (rlist == L_T1 || rlist == L_T2)) begin
          upd.op   = U_MOVE;
          upd.list = L_T2;
        end
      end
      S_TRIM: begin
        q_go   = !issued;
        q_kind = Q_LRU;
        q_list = trim_list;
        if (done_q && fnd) begin
          upd.op = U_DROP;
        end
      end
      S_REPL: begin
        q_go   = !issued;
        q_kind = Q_LRU;
        q_list = rep_list;
        if (done_q && fnd) begin
          upd.op   = U_MOVE;
          upd.list = (rep_list == L_T1) ? L_B1 : L_B2;
        end
      end
      S_REPL2: begin
        q_go   = !issued;
        q_kind = Q_LRU;
        q_list = L_T1;
        if (done_q && fnd) begin
          upd.op   = U_MOVE;
          upd.list = L_B1;
        end
      end
      S_MOVEK: begin
        upd.op   = U_MOVE;
        upd.list = L_T2;
        upd_idx  = midx;
        old_l    = mlist;
      end
      S_FREE: begin
        q_go   = !issued;
        q_kind = Q_FREE;
      end
      S_VICB2: begin
        q_go   = !issued;
        q_kind = Q_LRU;
        q_list = L_B2;
        if (done_q && fnd) begin
          upd.op = U_DROP;
        end
      end
      S_VICB1: begin
        q_go   = !issued;
        q_kind = Q_LRU;
        q_list = L_B1;
        if (done_q && fnd) begin
          upd.op = U_DROP;
        end
      end
      S_INSERT: begin
        upd.op   = U_INSERT;
        upd.list = hf ? L_T2 : L_T1;
        upd_idx  = fidx;
      end
      default: ;
    endcase
  end

  // list size bookkeeping, old list never goes below zero
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sz_next[j] = sz[j];
    end
    case (upd.op)
      U_MOVE: begin
        if (sz_next[old_l] != '0) begin
          sz_next[old_l] = sz_next[old_l] - SZ_W'(1);
        end
        sz_next[upd.list] = sz_next[upd.list] + SZ_W'(1);
      end
      U_DROP: begin
        if (sz_next[old_l] != '0) begin
          sz_next[old_l] = sz_next[old_l] - SZ_W'(1);
        end
      end
      U_INSERT: sz_next[upd.list] = sz_next[upd.list] + SZ_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issued  <= 1'b0;
      cap     <= CAP_RESET;
      for (int j = 0; j < 4; j++) begin
        sz[j] <= '0;
      end
      p       <= '0;
      hits    <= '0;
      misses  <= '0;
      age_now <= '0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (q_go) begin
        issued <= 1'b1;
      end else if (done_q) begin
        issued <= 1'b0;
      end
      for (int j = 0; j < 4; j++) begin
        sz[j] <= sz_next[j];
      end
      if (upd.op == U_MOVE || upd.op == U_INSERT) begin
        age_now <= age_now + AGE_BITS'(1);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            kreg     <= KEY_BITS'(item.key);
            hf       <= item.high_freq;
            hit_r    <= 1'b0;
            ghost_r  <= GHOST_NONE;
            ev_valid <= 1'b0;
            ev_key   <= '0;
            state    <= S_FIND;
          end
        end
        S_FIND: begin
          if (done_q) begin
            if (fnd && (rlist == L_T1 || rlist == L_T2)) begin
              hit_r <= 1'b1;
              hits  <= hits + 32'd1;
              state <= S_DONE;
            end else if (fnd) begin
              misses   <= misses + 32'd1;
              midx     <= ridx;
              mlist    <= rlist;
              ghost_r  <= (rlist == L_B1) ? GHOST_B1 : GHOST_B2;
              in_b2    <= (rlist == L_B2);
              div_need <= div_start;
              state    <= S_DIV;
            end else begin
              misses <= misses + 32'd1;
              in_b2  <= 1'b0;
              if (t1b1 >= c) begin
                trim_list  <= (t1 < c) ? L_B1 : L_T1;
                trim_evict <= !(t1 < c);
                state      <= S_TRIM;
              end else if (tot >= c) begin
                if (tot >= (c << 1)) begin
                  trim_list  <= L_B2;
                  trim_evict <= 1'b0;
                  state      <= S_TRIM;
                end else begin
                  state <= S_REPL;
                end
              end else begin
                state <= S_FREE;
              end
            end
          end
        end
        S_DIV: begin
          if (!div_need || div_done) begin
            if (!in_b2) begin
              p <= (p_sum > cap_fx) ? P_W'(cap_fx) : P_W'(p_sum);
            end else begin
              p <= (p_ext > delta) ? P_W'(p_ext - delta) : '0;
            end
            state <= S_REPL;
          end
        end
        S_TRIM: begin
          if (done_q) begin
            if (fnd && trim_evict) begin
              ev_valid <= 1'b1;
              ev_key   <= ckey_c[CELLS];
            end
            state <= trim_evict ? S_FREE : S_REPL;
          end
        end
        S_REPL: begin
          if (done_q) begin
            if (fnd) begin
              ev_valid <= 1'b1;
              ev_key   <= ckey_c[CELLS];
              state    <= after_rep;
            end else if (rep_list == L_T2) begin
              state <= S_REPL2;
            end else begin
              state <= after_rep;
            end
          end
        end
        S_REPL2: begin
          if (done_q) begin
            if (fnd) begin
              ev_valid <= 1'b1;
              ev_key   <= ckey_c[CELLS];
            end
            state <= after_rep;
          end
        end
        S_MOVEK: state <= S_DONE;
        S_FREE: begin
          if (done_q) begin
            fidx  <= ridx;
            state <= fnd ? S_INSERT : S_VICB2;
          end
        end
        S_VICB2: begin
          if (done_q) begin
            fidx  <= ridx;
            state <= fnd ? S_INSERT : S_VICB1;
          end
        end
        S_VICB1: begin
          if (done_q) begin
            fidx  <= ridx;
            state <= fnd ? S_INSERT : S_DONE;
          end
        end
        S_INSERT: state <= S_DONE;
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_DONE);

  always_comb begin
    result.hit           = hit_r;
    result.ghost_kind    = ghost_r;
    result.evicted_valid = ev_valid;
    result.evicted_key   = 32'(ev_key);
    result.target_t1     = P_OUT_W'(p);
    result.hit_total     = hits;
    result.miss_total    = misses;
  end

endmodule

/* sv/ard_check.sv */
// port-level checks for the adaptive replacement directory, bound to the top level
module ard_check
  import ard_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input rsp_t result
);

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !busy)
    else $error("block still busy after result");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_result_in_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result shown outside an item");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |-> (result.ghost_kind == GHOST_NONE) && !result.evicted_valid)
    else $error("resident hit reported ghost or eviction");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.evicted_valid |-> (result.evicted_key == 32'd0))
    else $error("evicted key set without eviction");

endmodule

bind adaptive_replacement_directory ard_check u_ard_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
